// ===== rtl/oaht_pkg.sv =====
`default_nettype none
package oaht_pkg;
  localparam int TableDepth = 4096;
  localparam int SlotW = 12;
  localparam int SizeW = 13;
  localparam int KeyMax = 30;
  localparam int KeyLenW = 5;
  localparam int HashChars = 8;
  localparam int KeyMemDepth = TableDepth * 32;
  localparam int KeyMemAw = 17;
  localparam logic [31:0] DoublePrime = 32'd10007;

  localparam logic [2:0] StFound = 3'd0;
  localparam logic [2:0] StNotFound = 3'd1;
  localparam logic [2:0] StInserted = 3'd2;
  localparam logic [2:0] StPresent = 3'd3;
  localparam logic [2:0] StFull = 3'd4;

  localparam logic [1:0] CfgTableSize = 2'd0;
  localparam logic [1:0] CfgHashSelect = 2'd1;
  localparam logic [1:0] CfgProbeMode = 2'd2;

  localparam logic [1:0] ProbeQuad = 2'd1;
  localparam logic [1:0] ProbeDouble = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/oaht_if.sv =====
`default_nettype none
interface oaht_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic [7:0] key_byte;
  logic key_last;
  logic [31:0] value_handle;
  modport source (output valid, operation, key_byte, key_last, value_handle, input ready);
  modport sink (input valid, operation, key_byte, key_last, value_handle, output ready);
endinterface

interface oaht_out_if;
  logic valid;
  logic ready;
  logic [11:0] slot_index;
  logic [12:0] collision_count;
  logic [2:0] status;
  logic [31:0] found_value;
  modport source (output valid, slot_index, collision_count, status, found_value, input ready);
  modport sink (input valid, slot_index, collision_count, status, found_value, output ready);
endinterface

interface oaht_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/oaht_ram.sv =====
`default_nettype none
module oaht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/open_addressing_hash_table.sv =====
// channel | dir | payload
// in_     | in  | operation, key_byte, key_last, value_handle
// out_    | out | slot_index, collision_count, status, found_value
// cfg_    | in  | index (2b), data (13b)
// non-last key byte: folded in S_IDLE; last byte: modulus for home (S_HMOD), then double step (S_DOFF)
// each probe: read (S_RD) and check (S_CHK), then compare one key byte per cycle on a length match
// each further probe: an offset step (S_OFF) plus a modulus (S_SMOD); insert writes length, then each key byte
// after reset a clearing pass over all 4096 slots empties the occupancy store
// out holds its transfer until taken; in is not ready from a last byte until then
`default_nettype none
module open_addressing_hash_table (
  input wire logic clk,
  input wire logic rst_n,
  oaht_in_if.sink   in_ch,
  oaht_out_if.source out_ch,
  oaht_cfg_if.sink  cfg_ch
);
  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_HMOD  = 11'b00000000100,
    S_DOFF  = 11'b00000001000,
    S_OFF   = 11'b00000010000,
    S_SMOD  = 11'b00000100000,
    S_RD    = 11'b00001000000,
    S_CHK   = 11'b00010000000,
    S_CMP   = 11'b00100000000,
    S_WR    = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r;
  logic [12:0] size_r;
  logic hsel_r;
  logic [1:0] pmode_r;
  logic [4:0] plen_r, cidx_r;
  logic [31:0] hacc_r;
  logic op_r;
  logic [31:0] val_r;
  // modulus unit: remainder of dividend by size, 1 bit per cycle
  logic [44:0] dvd_r;   // numerator up to 45 bits
  logic [5:0]  mcnt_r;
  logic [13:0] rem_r;
  logic [11:0] home_r, slot_r;
  logic [12:0] probes_r;
  logic [13:0] dstep_r;  // 10007 - home%10007
  logic [11:0] clr_r;
  logic [2:0] st_r;
  logic [31:0] fv_r;

  logic [12:0] esize;
  always_comb begin
    esize = size_r;
    if (size_r == 13'd0) esize = 13'd1;
    if (size_r > 13'd4096) esize = 13'd4096;
  end

  // pending key store
  logic [7:0] pk_rd;
  oaht_ram #(.Width(8), .Depth(32)) u_pk (
    .clk(clk), .we(in_ch.valid && in_ch.ready && plen_r < 5'(oaht_pkg::KeyMax-1)),
    .waddr(plen_r), .wdata(in_ch.key_byte), .raddr(cidx_r), .rdata(pk_rd));

  logic occ_we, occ_wd, occ_rd;
  logic [11:0] occ_wa;
  oaht_ram #(.Width(1), .Depth(oaht_pkg::TableDepth)) u_occ (
    .clk(clk), .we(occ_we), .waddr(occ_wa), .wdata(occ_wd), .raddr(slot_r), .rdata(occ_rd));
  logic [4:0] len_rd;
  oaht_ram #(.Width(5), .Depth(oaht_pkg::TableDepth)) u_len (
    .clk(clk), .we(state_r == S_WR && cidx_r == 5'd0), .waddr(slot_r), .wdata(plen_r),
    .raddr(slot_r), .rdata(len_rd));
  logic [31:0] sv_rd;
  oaht_ram #(.Width(32), .Depth(oaht_pkg::TableDepth)) u_val (
    .clk(clk), .we(state_r == S_WR && cidx_r == 5'd0), .waddr(slot_r), .wdata(val_r),
    .raddr(slot_r), .rdata(sv_rd));
  logic [7:0] kb_rd;
  oaht_ram #(.Width(8), .Depth(oaht_pkg::KeyMemDepth)) u_key (
    .clk(clk), .we(state_r == S_WR && cidx_r > 5'd0),
    .waddr({slot_r, 5'(cidx_r - 5'd1)}), .wdata(pk_rd),
    .raddr({slot_r, cidx_r}), .rdata(kb_rd));

  always_comb begin
    occ_we = 1'b0; occ_wa = slot_r; occ_wd = 1'b1;
    if (state_r == S_CLEAR) begin
      occ_we = 1'b1; occ_wa = clr_r; occ_wd = 1'b0;
    end else if (state_r == S_WR && cidx_r == 5'd0) begin
      occ_we = 1'b1;
    end
  end

  assign in_ch.ready = (state_r == S_IDLE) && !out_ch.valid;
  assign cfg_ch.ready = 1'b1;

  logic [13:0] trial;
  assign trial = {rem_r[12:0], dvd_r[44]} - {1'b0, esize};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; size_r <= 13'd4096; hsel_r <= 1'b0;
      pmode_r <= 2'd0; plen_r <= '0; hacc_r <= '0; out_ch.valid <= 1'b0; cidx_r <= '0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          oaht_pkg::CfgTableSize:  size_r <= cfg_ch.data;
          oaht_pkg::CfgHashSelect: hsel_r <= cfg_ch.data[0];
          oaht_pkg::CfgProbeMode:  pmode_r <= cfg_ch.data[1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 12'd1;
          if (clr_r == 12'hfff) state_r <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          // fold byte into hash and pending key
          if (plen_r < 5'(oaht_pkg::KeyMax-1)) begin
            plen_r <= plen_r + 5'd1;
            if (plen_r < 5'(oaht_pkg::HashChars))
              hacc_r <= hsel_r ? (hacc_r << 5) + 32'(in_ch.key_byte)
                               : hacc_r + 32'(in_ch.key_byte);
          end
          if (in_ch.key_last) begin
            op_r <= in_ch.operation; val_r <= in_ch.value_handle;
            state_r <= S_HMOD; mcnt_r <= '0; rem_r <= '0; probes_r <= '0;
            if (plen_r < 5'(oaht_pkg::HashChars) && plen_r < 5'(oaht_pkg::KeyMax-1))
              dvd_r <= {hsel_r ? (hacc_r << 5) + 32'(in_ch.key_byte)
                               : hacc_r + 32'(in_ch.key_byte), 13'd0};
            else dvd_r <= {hacc_r, 13'd0};
          end
        end
        S_HMOD, S_SMOD: begin
          // restoring step
          if (!trial[13]) rem_r <= trial; else rem_r <= {rem_r[12:0], dvd_r[44]};
          dvd_r <= dvd_r << 1;
          mcnt_r <= mcnt_r + 6'd1;
          if (mcnt_r == (state_r == S_HMOD ? 6'd31 : 6'd44)) begin
            if (state_r == S_HMOD) begin
              home_r <= 12'(trial[13] ? {rem_r[12:0], dvd_r[44]} : trial);
              slot_r <= 12'(trial[13] ? {rem_r[12:0], dvd_r[44]} : trial);
              state_r <= S_DOFF;
            end else begin
              slot_r <= 12'(trial[13] ? {rem_r[12:0], dvd_r[44]} : trial);
              state_r <= S_RD;
            end
          end
        end
        S_DOFF: begin
          // home < 10007 so home mod 10007 is home
          dstep_r <= 14'(oaht_pkg::DoublePrime - 32'(home_r));
          state_r <= S_RD;
        end
        S_OFF: begin
          if (probes_r == esize) begin
            st_r <= oaht_pkg::StFull; fv_r <= '0; slot_r <= home_r;
            out_ch.valid <= 1'b1; state_r <= S_OUT;
          end else begin
            state_r <= S_SMOD; mcnt_r <= '0; rem_r <= '0;
          end
        end
        S_RD: begin
          cidx_r <= '0; state_r <= S_CHK;
        end
        S_CHK: begin
          if (!occ_rd) begin
            fv_r <= '0;
            if (op_r) begin
              st_r <= oaht_pkg::StInserted; cidx_r <= '0; state_r <= S_WR;
            end else begin
              st_r <= oaht_pkg::StNotFound; out_ch.valid <= 1'b1; state_r <= S_OUT;
            end
          end else if (len_rd != plen_r) begin
            probes_r <= probes_r + 13'd1; state_r <= S_OFF;
          end else begin
            cidx_r <= 5'd1; state_r <= S_CMP;
          end
        end
        S_CMP: begin
          // data for index cidx_r-1 arrives; compare one byte a cycle
          if (kb_rd != pk_rd) begin
            probes_r <= probes_r + 13'd1; state_r <= S_OFF;
          end else if (cidx_r == plen_r) begin
            fv_r <= sv_rd; st_r <= op_r ? oaht_pkg::StPresent : oaht_pkg::StFound;
            out_ch.valid <= 1'b1; state_r <= S_OUT;
          end else cidx_r <= cidx_r + 5'd1;
        end
        S_WR: begin
          cidx_r <= cidx_r + 5'd1;
          if (cidx_r == plen_r) begin
            out_ch.valid <= 1'b1; state_r <= S_OUT;
          end
        end
        S_OUT: if (!out_ch.valid || out_ch.ready) begin
          if (!out_ch.valid || out_ch.ready) begin
            plen_r <= '0; hacc_r <= '0; cidx_r <= '0; state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // offset add feeds the modulus on entry
      if (state_r == S_OFF && probes_r != esize) begin
        if (pmode_r == oaht_pkg::ProbeQuad)
          dvd_r <= 45'(home_r) + 45'(probes_r * probes_r);
        else if (pmode_r == oaht_pkg::ProbeDouble)
          dvd_r <= 45'(home_r) + 45'(probes_r * dstep_r);
        else dvd_r <= 45'(home_r) + 45'(probes_r);
      end
    end
  end

  assign out_ch.slot_index = slot_r;
  assign out_ch.collision_count = probes_r;
  assign out_ch.status = st_r;
  assign out_ch.found_value = fv_r;

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ch.ready) else $error("ready during walk");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == oaht_pkg::StFull |-> out_ch.found_value == 32'd0)
    else $error("full with value");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> state_r == S_OUT) else $error("result outside output state");
`endif
endmodule
`default_nettype wire
